// ===== rtl/tds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants of the tridiagonal system solver
// fixed-point format, storage depth and the divider request/response structs
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int IDX_W     = 6;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DCNT_W    = $clog2(NUM_W + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_PIV = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD_RD,
        S_FWD_DIV,
        S_FWD_MUL_P,
        S_FWD_MUL_R,
        S_FWD_WR,
        S_BK_RD,
        S_BK_MUL,
        S_BK_DIV,
        S_BK_OUT
    } tds_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } tds_div_req_t;

    typedef struct packed {
        logic              done;
        logic              zero;
        logic [DATA_W-1:0] quot;
    } tds_div_rsp_t;

    // signed saturation of a 66-bit value to DATA_W bits
    function automatic logic [DATA_W-1:0] sat(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) sat = hi[DATA_W-1:0];
        else if (v < lo) sat = lo[DATA_W-1:0];
        else sat = v[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/tds_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_divider: restoring fixed-point divider
// (a << FRAC_BITS) / b truncated toward zero and saturated, one bit a cycle
// ----------------------------------------------------------------------------
module tds_divider import tds_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  tds_div_req_t req,
    output tds_div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [DATA_W:0]   r_reg, r_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              zero_reg, zero_next;

    logic [DATA_W-1:0] abs_n, abs_d;
    logic [DATA_W:0]   trial;
    logic signed [65:0] sq;

    assign abs_n = req.num[DATA_W-1] ? (~req.num + 1'b1) : req.num;
    assign abs_d = req.den[DATA_W-1] ? (~req.den + 1'b1) : req.den;
    assign trial = {r_reg[DATA_W-1:0], q_reg[NUM_W-1]};

    // combine sign and quotient magnitude into the signed result (saturated into res_reg)
    always_comb begin
        sq = neg_reg ? -$signed({{(66-NUM_W){1'b0}}, q_reg})
                     : $signed({{(66-NUM_W){1'b0}}, q_reg});
    end

    // one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        zero_next = zero_reg;
        if (req.start) begin
            zero_next = (req.den == '0);
            neg_next  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
            q_next    = {abs_n, {FRAC_BITS{1'b0}}};
            r_next    = '0;
            d_next    = abs_d;
            cnt_next  = DCNT_W'(NUM_W);
            busy_next = (req.den != '0);
            done_next = (req.den == '0);
            res_next  = req.num[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) busy_next = 1'b0;
        end
    end

    logic fin_reg, fin_next;
    assign fin_next = busy_reg && !req.start && (cnt_reg == DCNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next | fin_reg;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        res_reg  <= fin_reg ? sat(sq) : res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = zero_reg;
    assign rsp.quot = res_reg;

endmodule

// ===== rtl/tridiagonal_system_solver.sv =====
`timescale 1ns / 1ps
// forward phase: a row after the first holds s_tready low through the read, the shared
// divider, two multiplies and the write, the divide ending early when the previous
// pivot is zero; the first row of a system skips the divide and the multiplies.
// flow: one row at a time; after the last row the solution items follow one by one,
// each read, multiplied and divided in turn, and stalled while m_tready is low.
// reset: aresetn synchronous active low clears row count, status and control.
// ----------------------------------------------------------------------------
// tridiagonal_system_solver: Thomas algorithm solver, Q8.24 fixed point
// forward elimination per row, back substitution after the last row
// ----------------------------------------------------------------------------
module tridiagonal_system_solver import tds_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // lower, diag, upper, rhs
    input  logic          s_tlast,   // last_row
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // x_value, x_index, status
    output logic          m_tlast    // final_res
);

    tds_state_t state_reg, state_next;

    logic [DATA_W-1:0] piv_mem [MAX_ROWS];
    logic [DATA_W-1:0] rhs_mem [MAX_ROWS];
    logic [DATA_W-1:0] up_mem  [MAX_ROWS];

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        stat_reg, stat_next;
    logic [ADDR_W-1:0] bi_reg, bi_next;
    logic              first_reg, first_next;
    logic [DATA_W-1:0] lo_reg, dg_reg, up_reg, rh_reg;
    logic              last_reg;
    logic [DATA_W-1:0] m_reg, m_next;
    logic [DATA_W-1:0] t_reg, t_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] rdp_reg, rdr_reg, rdu_reg;
    logic              ov_valid_reg, ov_valid_next;
    logic [39:0]       ov_data_reg, ov_data_next;
    logic              ov_last_reg, ov_last_next;

    // shared multiplier operands
    logic [DATA_W-1:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [65:0] pfl;
    logic [DATA_W-1:0] qm;

    tds_div_req_t dreq;
    tds_div_rsp_t drsp;
    logic         we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] wpiv, wrhs;

    tds_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign prod = $signed(ma) * $signed(mb);
    assign pfl  = $signed({{2{prod[63]}}, prod}) >>> FRAC_BITS;
    assign qm   = sat(pfl);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_valid_reg;
    assign m_tdata  = ov_data_reg;
    assign m_tlast  = ov_last_reg;

    // memories
    always_ff @(posedge aclk) begin
        if (we) begin
            piv_mem[waddr] <= wpiv;
            rhs_mem[waddr] <= wrhs;
            up_mem[waddr]  <= up_reg;
        end
        rdp_reg <= piv_mem[raddr];
        rdr_reg <= rhs_mem[raddr];
        rdu_reg <= up_mem[raddr];
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        stat_next     = stat_reg;
        bi_next       = bi_reg;
        first_next    = first_reg;
        m_next        = m_reg;
        t_next        = t_reg;
        x_next        = x_reg;
        ov_valid_next = ov_valid_reg;
        ov_data_next  = ov_data_reg;
        ov_last_next  = ov_last_reg;
        dreq          = '0;
        we            = 1'b0;
        waddr         = cnt_reg[ADDR_W-1:0];
        raddr         = bi_reg;
        wpiv          = dg_reg;
        wrhs          = rh_reg;
        ma            = rdu_reg;
        mb            = m_reg;
        if (ov_valid_reg && m_tready) ov_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_FWD_RD;
            end
            S_FWD_RD: begin
                raddr = ADDR_W'(cnt_reg - 1'b1);
                if (cnt_reg == CNT_W'(MAX_ROWS)) begin
                    stat_next  = ST_DROPPED;
                    state_next = S_FWD_WR;
                end else if (cnt_reg == '0) begin
                    state_next = S_FWD_WR;
                end else begin
                    state_next = S_FWD_DIV;
                    first_next = 1'b1;
                end
            end
            S_FWD_DIV: begin
                // keep the previous row on the read port
                raddr      = ADDR_W'(cnt_reg - 1'b1);
                dreq.num   = lo_reg;
                dreq.den   = rdp_reg;
                dreq.start = first_reg;
                first_next = 1'b0;
                if (!first_reg && drsp.done) begin
                    m_next = drsp.quot;
                    if (drsp.zero && stat_reg != ST_DROPPED) stat_next = ST_ZERO_PIV;
                    state_next = S_FWD_MUL_P;
                end
            end
            S_FWD_MUL_P: begin
                raddr = ADDR_W'(cnt_reg - 1'b1);
                ma = rdu_reg;
                t_next = sat($signed({{34{dg_reg[DATA_W-1]}}, dg_reg})
                           - $signed({{34{qm[DATA_W-1]}}, qm}));
                state_next = S_FWD_MUL_R;
            end
            S_FWD_MUL_R: begin
                ma = rdr_reg;
                x_next = sat($signed({{34{rh_reg[DATA_W-1]}}, rh_reg})
                           - $signed({{34{qm[DATA_W-1]}}, qm}));
                state_next = S_FWD_WR;
            end
            S_FWD_WR: begin
                if (cnt_reg != CNT_W'(MAX_ROWS)) begin
                    we = 1'b1;
                    if (cnt_reg != '0) begin
                        wpiv = t_reg;
                        wrhs = x_reg;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
                if (last_reg) begin
                    bi_next    = (cnt_reg != CNT_W'(MAX_ROWS)) ? cnt_reg[ADDR_W-1:0]
                                 : ADDR_W'(cnt_reg - 1'b1);
                    first_next = 1'b1;
                    state_next = S_BK_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_BK_RD: begin
                state_next = S_BK_MUL;
            end
            S_BK_MUL: begin
                ma = rdu_reg;
                mb = x_reg;
                if (first_reg) t_next = rdr_reg;
                else t_next = sat($signed({{34{rdr_reg[DATA_W-1]}}, rdr_reg})
                                - $signed({{34{qm[DATA_W-1]}}, qm}));
                m_next     = 32'd1;
                state_next = S_BK_DIV;
            end
            S_BK_DIV: begin
                dreq.num   = t_reg;
                dreq.den   = rdp_reg;
                dreq.start = m_reg[0];
                m_next     = '0;
                if (!m_reg[0] && drsp.done) begin
                    x_next = drsp.quot;
                    if (drsp.zero && stat_reg != ST_DROPPED) stat_next = ST_ZERO_PIV;
                    state_next = S_BK_OUT;
                end
            end
            S_BK_OUT: begin
                if (!ov_valid_reg || m_tready) begin
                    ov_valid_next = 1'b1;
                    ov_data_next  = {stat_reg, IDX_W'(bi_reg), x_reg};
                    ov_last_next  = (bi_reg == '0);
                    first_next    = 1'b0;
                    if (bi_reg == '0) begin
                        cnt_next   = '0;
                        stat_next  = ST_OK;
                        x_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        bi_next    = bi_reg - 1'b1;
                        state_next = S_BK_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            stat_reg     <= ST_OK;
            ov_valid_reg <= 1'b0;
            x_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            stat_reg     <= stat_next;
            ov_valid_reg <= ov_valid_next;
            x_reg        <= x_next;
        end
        bi_reg      <= bi_next;
        first_reg   <= first_next;
        m_reg       <= m_next;
        t_reg       <= t_next;
        ov_data_reg <= ov_data_next;
        ov_last_reg <= ov_last_next;
        if (s_tvalid && s_tready) begin
            lo_reg   <= s_tdata[31:0];
            dg_reg   <= s_tdata[63:32];
            up_reg   <= s_tdata[95:64];
            rh_reg   <= s_tdata[127:96];
            last_reg <= s_tlast;
        end
    end

endmodule
